// File: design/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Result codes, header constants and the divider handshake types shared by
// the decoder core, its row/column divider and its port checker.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam logic [1:0] KIND_HEADER      = 2'd0;
  localparam logic [1:0] KIND_RUN         = 2'd1;
  localparam logic [1:0] KIND_BAD_TYPE    = 2'd2;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

  localparam logic [7:0] TYPE_TRUECOLOUR = 8'd2;
  localparam logic [7:0] TYPE_RLE        = 8'd10;
  localparam logic [7:0] DEPTH_24        = 8'd24;
  localparam logic [7:0] DEPTH_32        = 8'd32;

  localparam logic [4:0] HDR_ID_LENGTH   = 5'd0;
  localparam logic [4:0] HDR_CMAP_TYPE   = 5'd1;
  localparam logic [4:0] HDR_IMAGE_TYPE  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO    = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI    = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO   = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI   = 5'd15;
  localparam logic [4:0] HDR_PIXEL_DEPTH = 5'd16;
  localparam logic [4:0] HDR_LAST        = 5'd17;

  localparam logic [7:0] PKT_COUNT_MASK = 8'h7f;
  localparam int         PKT_RUN_BIT    = 7;
  localparam logic [7:0] OPAQUE_ALPHA   = 8'hff;

  localparam logic [1:0] DIV_LAST_STEP = 2'd3;

  typedef struct packed {
    logic        start;
    logic [16:0] total;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [7:0]  quotient;
    logic [16:0] remainder;
  } div_resp_t;

endpackage

// File: design/tgarle_row_div.sv
// ----------------------------------------------------------------------------
// TGA RLE row/column divider
// Radix-4 restoring divider that splits the column reached by a run into
// rows crossed and the new column, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tgarle_row_div
  import tgarle_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic        busy;
  logic [1:0]  step;
  logic [16:0] rem;
  logic [21:0] dvs;
  logic [5:0]  quot;

  logic [23:0] cand1;
  logic [23:0] cand2;
  logic [23:0] cand3;
  logic [23:0] rem_wide;
  logic [23:0] sub;
  logic [1:0]  digit;
  logic [16:0] rem_next;

  always_comb begin
    cand1    = {2'b00, dvs};
    cand2    = {1'b0, dvs, 1'b0};
    cand3    = cand1 + cand2;
    rem_wide = {7'd0, rem};
    if (rem_wide >= cand3) begin
      digit = 2'd3;
      sub   = cand3;
    end else if (rem_wide >= cand2) begin
      digit = 2'd2;
      sub   = cand2;
    end else if (rem_wide >= cand1) begin
      digit = 2'd1;
      sub   = cand1;
    end else begin
      digit = 2'd0;
      sub   = 24'd0;
    end
    rem_next = 17'(rem_wide - sub);
  end

  assign resp.busy      = busy;
  assign resp.done      = busy && (step == DIV_LAST_STEP);
  assign resp.quotient  = {quot, digit};
  assign resp.remainder = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == DIV_LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.total;
      dvs  <= {req.divisor, 6'd0};
      quot <= 6'd0;
    end else if (busy) begin
      rem  <= rem_next;
      dvs  <= {2'b00, dvs[21:2]};
      quot <= {quot[3:0], digit};
    end
  end

endmodule

// File: design/tga_truecolor_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// TGA true-colour RLE decoder core
// Parses a TGA byte stream and reports the header, errors and RGBA pixel
// runs with their top-down destination row and column.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload
//   --------  --------------------------  -------------------------------------
//   bytes     byte_valid / byte_stall     data_byte, start_of_file
//   results   result_valid / result_stall result_kind, pixel_rgba, dest_row,
//                                         dest_column, run_length, image_width,
//                                         image_height, image_done
//
// One byte is taken per cycle while byte_stall is low; a result appears in the
// result register in the cycle after the byte that completes it.
// An RLE run longer than one pixel that does not end the image starts the
// row/column divider; a pixel-completing byte that arrives while it runs waits,
// so such a run can stall the byte side.
// Reset is synchronous; afterwards bytes are ignored until start_of_file.
// While a result waits on result_stall, bytes that cannot give a result are
// still taken; only a header-completing or pixel-completing beat is held.
module tga_truecolor_rle_decoder_core
  import tgarle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] pixel_rgba,
  output logic [15:0] dest_row,
  output logic [15:0] dest_column,
  output logic [7:0]  run_length,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic        image_done
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_IDSKIP,
    PH_PKTHDR,
    PH_PIXEL,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next, phase_eff;
  logic [4:0]  hbs, hbs_next, hbs_eff;
  logic [7:0]  id_left, id_left_next;
  logic        rle_mode, rle_mode_next;
  logic        has_alpha, has_alpha_next;
  logic [15:0] width_reg, width_next, width_eff;
  logic [15:0] height_reg, height_next, height_eff;
  logic [15:0] cur_row, cur_row_next;
  logic [15:0] cur_column, cur_column_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  comp_index, comp_index_next;
  logic [23:0] colour_bytes, colour_bytes_next;
  logic [7:0]  id_length, id_length_next;
  logic [7:0]  cmap_type, cmap_type_next;
  logic [7:0]  image_type, image_type_next;
  logic [7:0]  pixel_depth, pixel_depth_next;
  logic [31:0] pixels_left, pixels_left_next;

  logic [31:0] image_area;
  logic [1:0]  last_index;
  logic        emit_slot;
  logic        header_slot;
  logic        accept;

  logic        has_result;
  logic [1:0]  r_kind;
  logic [31:0] r_rgba;
  logic [15:0] r_row;
  logic [15:0] r_column;
  logic [7:0]  r_length;
  logic [15:0] r_width;
  logic [15:0] r_height;
  logic        r_done;

  logic [7:0]  want;
  logic [7:0]  len;
  logic        run_done;

  div_req_t    div_req;
  div_resp_t   div_resp;

  tgarle_row_div u_row_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign image_area  = width_reg * height_reg;
  assign last_index  = has_alpha ? 2'd3 : 2'd2;
  assign emit_slot   = (phase == PH_PIXEL) && (comp_index == last_index);
  assign header_slot = (phase == PH_HEADER) && (hbs == HDR_LAST);
  assign byte_stall  = (result_valid && result_stall && (emit_slot || header_slot)) ||
                       (div_resp.busy && emit_slot);
  assign accept      = byte_valid && !byte_stall;

  always_comb begin
    phase_eff  = start_of_file ? PH_HEADER : phase;
    hbs_eff    = start_of_file ? 5'd0 : hbs;
    width_eff  = start_of_file ? 16'd0 : width_reg;
    height_eff = start_of_file ? 16'd0 : height_reg;

    phase_next         = phase_eff;
    hbs_next           = hbs_eff;
    id_left_next       = id_left;
    rle_mode_next      = rle_mode;
    has_alpha_next     = has_alpha;
    width_next         = width_eff;
    height_next        = height_eff;
    cur_row_next       = cur_row;
    cur_column_next    = cur_column;
    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    comp_index_next    = comp_index;
    colour_bytes_next  = colour_bytes;
    id_length_next     = id_length;
    cmap_type_next     = cmap_type;
    image_type_next    = image_type;
    pixel_depth_next   = pixel_depth;
    pixels_left_next   = pixels_left;

    has_result = 1'b0;
    r_kind     = KIND_HEADER;
    r_rgba     = 32'd0;
    r_row      = 16'd0;
    r_column   = 16'd0;
    r_length   = 8'd0;
    r_width    = 16'd0;
    r_height   = 16'd0;
    r_done     = 1'b0;
    want       = 8'd1;
    len        = 8'd0;
    run_done   = 1'b0;

    div_req.start   = 1'b0;
    div_req.total   = 17'({1'b0, cur_column});
    div_req.divisor = width_reg;

    if (div_resp.done) begin
      cur_row_next    = cur_row - {8'd0, div_resp.quotient};
      cur_column_next = div_resp.remainder[15:0];
    end

    case (phase_eff)
      PH_HEADER: begin
        case (hbs_eff)
          HDR_ID_LENGTH:   id_length_next   = data_byte;
          HDR_CMAP_TYPE:   cmap_type_next   = data_byte;
          HDR_IMAGE_TYPE:  image_type_next  = data_byte;
          HDR_WIDTH_LO:    width_next       = {width_eff[15:8], data_byte};
          HDR_WIDTH_HI:    width_next       = {data_byte, width_eff[7:0]};
          HDR_HEIGHT_LO:   height_next      = {height_eff[15:8], data_byte};
          HDR_HEIGHT_HI:   height_next      = {data_byte, height_eff[7:0]};
          HDR_PIXEL_DEPTH: pixel_depth_next = data_byte;
          default: begin
          end
        endcase
        if (hbs_eff == HDR_LAST) begin
          hbs_next   = 5'd0;
          has_result = 1'b1;
          r_width    = width_reg;
          r_height   = height_reg;
          if ((image_type != TYPE_TRUECOLOUR) && (image_type != TYPE_RLE)) begin
            r_kind     = KIND_BAD_TYPE;
            phase_next = PH_IDLE;
          end else if ((cmap_type != 8'd0) ||
                       ((pixel_depth != DEPTH_24) && (pixel_depth != DEPTH_32))) begin
            r_kind     = KIND_UNSUPPORTED;
            phase_next = PH_IDLE;
          end else begin
            r_kind             = KIND_HEADER;
            rle_mode_next      = (image_type == TYPE_RLE);
            has_alpha_next     = (pixel_depth == DEPTH_32);
            cur_column_next    = 16'd0;
            comp_index_next    = 2'd0;
            colour_bytes_next  = 24'd0;
            packet_left_next   = 8'd0;
            packet_is_run_next = 1'b0;
            if ((width_reg == 16'd0) || (height_reg == 16'd0)) begin
              cur_row_next = 16'd0;
              phase_next   = PH_DONE;
              r_done       = 1'b1;
            end else begin
              cur_row_next     = height_reg - 16'd1;
              pixels_left_next = image_area;
              if (id_length != 8'd0) begin
                id_left_next = id_length;
                phase_next   = PH_IDSKIP;
              end else begin
                phase_next = (image_type == TYPE_RLE) ? PH_PKTHDR : PH_PIXEL;
              end
            end
          end
        end else begin
          hbs_next = hbs_eff + 5'd1;
        end
      end
      PH_IDSKIP: begin
        id_left_next = id_left - 8'd1;
        if (id_left == 8'd1) begin
          phase_next = rle_mode ? PH_PKTHDR : PH_PIXEL;
        end
      end
      PH_PKTHDR: begin
        packet_left_next   = (data_byte & PKT_COUNT_MASK) + 8'd1;
        packet_is_run_next = data_byte[PKT_RUN_BIT];
        comp_index_next    = 2'd0;
        colour_bytes_next  = 24'd0;
        phase_next         = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (comp_index < last_index) begin
          case (comp_index)
            2'd0:    colour_bytes_next[7:0]   = data_byte;
            2'd1:    colour_bytes_next[15:8]  = data_byte;
            default: colour_bytes_next[23:16] = data_byte;
          endcase
          comp_index_next = comp_index + 2'd1;
        end else begin
          comp_index_next   = 2'd0;
          colour_bytes_next = 24'd0;
          if (has_alpha) begin
            r_rgba = {colour_bytes[23:16], colour_bytes[15:8], colour_bytes[7:0], data_byte};
          end else begin
            r_rgba = {data_byte, colour_bytes[15:8], colour_bytes[7:0], OPAQUE_ALPHA};
          end
          if (rle_mode && packet_is_run) begin
            want             = packet_left;
            packet_left_next = 8'd0;
          end else begin
            want = 8'd1;
            if (rle_mode && (packet_left != 8'd0)) begin
              packet_left_next = packet_left - 8'd1;
            end
          end
          if ({24'd0, want} < pixels_left) begin
            len = want;
          end else begin
            len = pixels_left[7:0];
          end
          run_done   = ({24'd0, len} == pixels_left);
          has_result = 1'b1;
          r_kind     = KIND_RUN;
          r_row      = cur_row;
          r_column   = cur_column;
          r_length   = len;
          r_done     = run_done;
          if (run_done) begin
            phase_next = PH_DONE;
          end else begin
            pixels_left_next = pixels_left - {24'd0, len};
            if (len == 8'd1) begin
              if ((cur_column + 16'd1) == width_reg) begin
                cur_column_next = 16'd0;
                cur_row_next    = cur_row - 16'd1;
              end else begin
                cur_column_next = cur_column + 16'd1;
              end
            end else begin
              div_req.start = 1'b1;
              div_req.total = {1'b0, cur_column} + {9'd0, len};
            end
            if (rle_mode && (packet_left_next == 8'd0)) begin
              phase_next = PH_PKTHDR;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (!accept) begin
      div_req.start = 1'b0;
      has_result    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      hbs           <= 5'd0;
      id_left       <= 8'd0;
      rle_mode      <= 1'b0;
      has_alpha     <= 1'b0;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      cur_row       <= 16'd0;
      cur_column    <= 16'd0;
      packet_left   <= 8'd0;
      packet_is_run <= 1'b0;
      comp_index    <= 2'd0;
      colour_bytes  <= 24'd0;
      id_length     <= 8'd0;
      cmap_type     <= 8'd0;
      image_type    <= 8'd0;
      pixel_depth   <= 8'd0;
      pixels_left   <= 32'd0;
      result_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        hbs           <= hbs_next;
        id_left       <= id_left_next;
        rle_mode      <= rle_mode_next;
        has_alpha     <= has_alpha_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        cur_row       <= cur_row_next;
        cur_column    <= cur_column_next;
        packet_left   <= packet_left_next;
        packet_is_run <= packet_is_run_next;
        comp_index    <= comp_index_next;
        colour_bytes  <= colour_bytes_next;
        id_length     <= id_length_next;
        cmap_type     <= cmap_type_next;
        image_type    <= image_type_next;
        pixel_depth   <= pixel_depth_next;
        pixels_left   <= pixels_left_next;
      end else if (div_resp.done) begin
        cur_row    <= cur_row_next;
        cur_column <= cur_column_next;
      end
      if (has_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (has_result) begin
      result_kind  <= r_kind;
      pixel_rgba   <= r_rgba;
      dest_row     <= r_row;
      dest_column  <= r_column;
      run_length   <= r_length;
      image_width  <= r_width;
      image_height <= r_height;
      image_done   <= r_done;
    end
  end

endmodule

// File: design/tgarle_checker.sv
// ----------------------------------------------------------------------------
// TGA RLE decoder port checker
// Watches the decoder core's ports and flags handshake and result-field
// inconsistencies.
// ----------------------------------------------------------------------------
module tgarle_checker
  import tgarle_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic [7:0]  data_byte,
  input logic        start_of_file,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  result_kind,
  input logic [31:0] pixel_rgba,
  input logic [15:0] dest_row,
  input logic [15:0] dest_column,
  input logic [7:0]  run_length,
  input logic [15:0] image_width,
  input logic [15:0] image_height,
  input logic        image_done
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_kind) &&
      $stable(pixel_rgba) && $stable(run_length) && $stable(image_done))
    else $error("Stalled result beat changed or was dropped.");

  a_run_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind == KIND_RUN) |->
      (run_length != 8'd0) && (image_width == 16'd0) && (image_height == 16'd0))
    else $error("Pixel run carries an empty length or header size.");

  a_header_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_kind != KIND_RUN) |->
      (run_length == 8'd0) && (pixel_rgba == 32'd0) && (dest_row == 16'd0) &&
      (dest_column == 16'd0))
    else $error("Header or error result carries pixel fields.");

  a_error_not_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((result_kind == KIND_BAD_TYPE) || (result_kind == KIND_UNSUPPORTED))
      |-> !image_done)
    else $error("Error result marks the image as complete.");

endmodule

bind tga_truecolor_rle_decoder_core tgarle_checker u_tgarle_checker (.*);

// File: verif/tb_tga_truecolor_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// Testbench for the TGA true-colour RLE decoder core
// Feeds TGA files, some cut short, one byte per beat, with random gaps on the byte
// side and random stalls on the result side. It includes one long result hold-off.
// A byte-level decoder kept in this file predicts each header, error and pixel
// run. Every result beat is compared field by field with the oldest
// prediction. A short table of directed files comes first, then random files.
// ----------------------------------------------------------------------------
module tb_tga_truecolor_rle_decoder_core;
  import tgarle_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_BYTES = 700;

  localparam logic [1:0] PACK_MIXED = 2'd0;
  localparam logic [1:0] PACK_RUNS  = 2'd1;
  localparam logic [1:0] PACK_RAW   = 2'd2;

  typedef enum logic [2:0] {
    ST_WAIT_SOF, ST_HEADER, ST_SKIP_ID, ST_PACKET, ST_PIXEL, ST_FINISHED
  } dec_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rgba;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  len;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic        done;
  } tga_result_t;

  typedef struct packed {
    logic [7:0]  id_len;
    logic [7:0]  cmap;
    logic [7:0]  itype;
    logic [7:0]  depth;
    logic [15:0] w;
    logic [15:0] h;
    int          pixels;
    logic [1:0]  packing;
    int          hdr_cut;
    logic        typed;
    logic [1:0]  exp_kind;
    logic        exp_done;
  } tga_file_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        start_of_file = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [31:0] pixel_rgba;
  logic [15:0] dest_row;
  logic [15:0] dest_column;
  logic [7:0]  run_length;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        image_done;

  tga_truecolor_rle_decoder_core DUT (.*);

  always #5 clk = ~clk;

  // Decoder state as seen from the byte stream.
  dec_state_t  dec_st = ST_WAIT_SOF;
  logic [4:0]  hdr_pos = '0;
  logic [7:0]  id_left = '0;
  logic        rle_on = 1'b0;
  logic        alpha_on = 1'b0;
  logic [15:0] img_w = '0;
  logic [15:0] img_h = '0;
  logic [15:0] row_pos = '0;
  logic [15:0] col_pos = '0;
  logic [7:0]  pkt_left = '0;
  logic        pkt_repeat = 1'b0;
  logic [1:0]  comp_idx = '0;
  logic [23:0] bgr_acc = '0;
  logic [7:0]  id_len_b = '0;
  logic [7:0]  cmap_b = '0;
  logic [7:0]  type_b = '0;
  logic [7:0]  depth_b = '0;

  tga_result_t awaited_results[$];
  tga_result_t head_r;
  tga_file_t   directed_plan [15];

  bit full_rate = 1'b0;
  bit hold_off = 1'b0;
  int stall_wait = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int results_seen = 0;
  int files_sent = 0;
  int decoded_bytes = 0;
  int runs_predicted = 0;
  int header_errors = 0;

  task automatic tga_decode_byte(input logic [7:0] b, input logic sof, output bit got,
                                 output tga_result_t r);
    longint unsigned left_px, n, total;
    int unsigned want;
    got = 1'b0;
    r = '0;
    if (sof) begin
      dec_st = ST_HEADER;
      hdr_pos = '0;
      img_w = '0;
      img_h = '0;
    end
    case (dec_st)
      ST_HEADER: begin
        case (hdr_pos)
          HDR_ID_LENGTH:   id_len_b = b;
          HDR_CMAP_TYPE:   cmap_b = b;
          HDR_IMAGE_TYPE:  type_b = b;
          HDR_WIDTH_LO:    img_w[7:0] = b;
          HDR_WIDTH_HI:    img_w[15:8] = b;
          HDR_HEIGHT_LO:   img_h[7:0] = b;
          HDR_HEIGHT_HI:   img_h[15:8] = b;
          HDR_PIXEL_DEPTH: depth_b = b;
          default: ;
        endcase
        if (hdr_pos != HDR_LAST) begin
          hdr_pos++;
        end else begin
          hdr_pos = '0;
          got = 1'b1;
          r.wid = img_w;
          r.hgt = img_h;
          if (type_b != TYPE_TRUECOLOUR && type_b != TYPE_RLE) begin
            r.kind = KIND_BAD_TYPE;
            dec_st = ST_WAIT_SOF;
          end else if (cmap_b != 8'd0 || (depth_b != DEPTH_24 && depth_b != DEPTH_32)) begin
            r.kind = KIND_UNSUPPORTED;
            dec_st = ST_WAIT_SOF;
          end else begin
            r.kind = KIND_HEADER;
            rle_on = (type_b == TYPE_RLE);
            alpha_on = (depth_b == DEPTH_32);
            col_pos = '0;
            comp_idx = '0;
            bgr_acc = '0;
            pkt_left = '0;
            pkt_repeat = 1'b0;
            if (img_w == 16'd0 || img_h == 16'd0) begin
              row_pos = '0;
              dec_st = ST_FINISHED;
              r.done = 1'b1;
            end else begin
              row_pos = img_h - 16'd1;
              if (id_len_b != 8'd0) begin
                id_left = id_len_b;
                dec_st = ST_SKIP_ID;
              end else begin
                dec_st = rle_on ? ST_PACKET : ST_PIXEL;
              end
            end
          end
        end
      end
      ST_SKIP_ID: begin
        id_left--;
        if (id_left == 8'd0) dec_st = rle_on ? ST_PACKET : ST_PIXEL;
      end
      ST_PACKET: begin
        pkt_left = (b & PKT_COUNT_MASK) + 8'd1;
        pkt_repeat = b[PKT_RUN_BIT];
        comp_idx = '0;
        bgr_acc = '0;
        dec_st = ST_PIXEL;
      end
      ST_PIXEL: begin
        if (comp_idx < (alpha_on ? 2'd3 : 2'd2)) begin
          bgr_acc[8*comp_idx +: 8] = b;
          comp_idx++;
        end else begin
          got = 1'b1;
          r.kind = KIND_RUN;
          r.rgba = alpha_on ? {bgr_acc[23:16], bgr_acc[15:8], bgr_acc[7:0], b}
                            : {b, bgr_acc[15:8], bgr_acc[7:0], OPAQUE_ALPHA};
          comp_idx = '0;
          bgr_acc = '0;
          if (rle_on && pkt_repeat) begin
            want = pkt_left;
            pkt_left = '0;
          end else begin
            want = 1;
            if (rle_on && pkt_left != 8'd0) pkt_left--;
          end
          left_px = 64'(row_pos) * 64'(img_w) + 64'(img_w) - 64'(col_pos);
          n = (want < left_px) ? want : left_px;
          r.row = row_pos;
          r.col = col_pos;
          r.len = 8'(n);
          if (n == left_px) begin
            r.done = 1'b1;
            dec_st = ST_FINISHED;
          end else begin
            total = 64'(col_pos) + n;
            row_pos = row_pos - 16'(total / img_w);
            col_pos = 16'(total % img_w);
          end
          if (dec_st == ST_PIXEL && rle_on && pkt_left == 8'd0) dec_st = ST_PACKET;
        end
      end
      default: ;
    endcase
  endtask

  task automatic put_byte(input logic [7:0] d, input logic sof, input bit typed = 1'b0,
                          input tga_result_t typed_r = '0);
    int gap;
    bit got;
    tga_result_t r;
    gap = full_rate ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= d;
    start_of_file <= sof;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (sof || (dec_st != ST_WAIT_SOF && dec_st != ST_FINISHED)) decoded_bytes++;
    tga_decode_byte(d, sof, got, r);
    if (got) begin
      if (typed) r = typed_r;
      awaited_results.push_back(r);
      if (r.kind == KIND_RUN) runs_predicted++;
      else if (r.kind != KIND_HEADER) header_errors++;
    end
  endtask

  task automatic send_tga(input tga_file_t f);
    tga_result_t typed_r;
    logic [7:0] b;
    int i, bpp, covered, cnt;
    bit run;
    typed_r = '0;
    typed_r.kind = f.exp_kind;
    typed_r.wid = f.w;
    typed_r.hgt = f.h;
    typed_r.done = f.exp_done;
    files_sent++;
    for (i = 0; i <= int'(HDR_LAST); i++) begin
      if (f.hdr_cut != 0 && i == f.hdr_cut) return;
      b = 8'($urandom_range(0, 255));
      case (5'(i))
        HDR_ID_LENGTH:   b = f.id_len;
        HDR_CMAP_TYPE:   b = f.cmap;
        HDR_IMAGE_TYPE:  b = f.itype;
        HDR_WIDTH_LO:    b = f.w[7:0];
        HDR_WIDTH_HI:    b = f.w[15:8];
        HDR_HEIGHT_LO:   b = f.h[7:0];
        HDR_HEIGHT_HI:   b = f.h[15:8];
        HDR_PIXEL_DEPTH: b = f.depth;
        default: ;
      endcase
      put_byte(b, i == 0, f.typed && i == int'(HDR_LAST), typed_r);
    end
    repeat (f.id_len) put_byte(8'($urandom_range(0, 255)), 1'b0);
    bpp = (f.depth == DEPTH_32) ? 4 : 3;
    covered = 0;
    if (f.itype == TYPE_RLE) begin
      while (covered < f.pixels) begin
        if (f.packing == PACK_RUNS) begin
          cnt = 128;
          run = 1'b1;
        end else if (f.packing == PACK_RAW) begin
          cnt = 128;
          run = 1'b0;
        end else begin
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
          run = $urandom_range(0, 1);
          if (!run && cnt > f.pixels - covered + 1) cnt = f.pixels - covered + 1;
        end
        put_byte(8'((int'(run) << PKT_RUN_BIT) | ((cnt - 1) & PKT_COUNT_MASK)), 1'b0);
        repeat ((run ? 1 : cnt) * bpp) put_byte(8'($urandom_range(0, 255)), 1'b0);
        covered += cnt;
      end
    end else begin
      repeat (f.pixels * bpp) put_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result_kind: expected no result, got 0x%0h", result_kind);
        mismatches++;
      end else begin
        head_r = awaited_results.pop_front();
        check_field("result_kind", head_r.kind, result_kind);
        check_field("pixel_rgba", head_r.rgba, pixel_rgba);
        check_field("dest_row", head_r.row, dest_row);
        check_field("dest_column", head_r.col, dest_column);
        check_field("run_length", head_r.len, run_length);
        check_field("image_width", head_r.wid, image_width);
        check_field("image_height", head_r.hgt, image_height);
        check_field("image_done", head_r.done, image_done);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_wait = 0;
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) stall_wait = full_rate ? 0 : $urandom_range(0, 5);
      else if (stall_wait != 0) stall_wait--;
      result_stall <= hold_off || (stall_wait != 0);
    end
  end

  // The long hold-off lets the result register fill so that the byte side stalls.
  initial begin
    wait (results_seen >= 80);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_tga_truecolor_rle_decoder_core NOT OK");
      $finish;
    end
  end

  initial begin
    tga_file_t f;
    int sel, area, k;
    directed_plan = '{
      '{8'd0, 8'd0, TYPE_TRUECOLOUR, DEPTH_24, 16'd4, 16'd3, 12, PACK_MIXED, 0,
        1'b1, KIND_HEADER, 1'b0},
      '{8'd3, 8'd0, TYPE_RLE, DEPTH_32, 16'd5, 16'd2, 10, PACK_MIXED, 0,
        1'b1, KIND_HEADER, 1'b0},
      '{8'd0, 8'd0, TYPE_RLE, DEPTH_24, 16'd3, 16'd2, 6, PACK_RUNS, 0,
        1'b1, KIND_HEADER, 1'b0},
      '{8'd0, 8'd0, TYPE_RLE, DEPTH_32, 16'd1, 16'd300, 300, PACK_RUNS, 0,
        1'b1, KIND_HEADER, 1'b0},
      '{8'd0, 8'd0, TYPE_RLE, DEPTH_24, 16'd64, 16'd2, 128, PACK_RAW, 0,
        1'b1, KIND_HEADER, 1'b0},
      '{8'd0, 8'd0, 8'd3, DEPTH_24, 16'd4, 16'd4, 4, PACK_MIXED, 0,
        1'b1, KIND_BAD_TYPE, 1'b0},
      '{8'd0, 8'hff, 8'hff, DEPTH_32, 16'hffff, 16'hffff, 2, PACK_MIXED, 0,
        1'b1, KIND_BAD_TYPE, 1'b0},
      '{8'd0, 8'd1, TYPE_TRUECOLOUR, DEPTH_24, 16'd2, 16'd2, 2, PACK_MIXED, 0,
        1'b1, KIND_UNSUPPORTED, 1'b0},
      '{8'd0, 8'd0, TYPE_RLE, 8'd16, 16'd2, 16'd2, 2, PACK_MIXED, 0,
        1'b1, KIND_UNSUPPORTED, 1'b0},
      '{8'd0, 8'd0, TYPE_TRUECOLOUR, 8'hff, 16'd2, 16'd2, 2, PACK_MIXED, 0,
        1'b1, KIND_UNSUPPORTED, 1'b0},
      '{8'd5, 8'd0, TYPE_TRUECOLOUR, DEPTH_32, 16'd0, 16'd5, 3, PACK_MIXED, 0,
        1'b1, KIND_HEADER, 1'b1},
      '{8'd0, 8'd0, TYPE_RLE, DEPTH_24, 16'd7, 16'd0, 2, PACK_MIXED, 0,
        1'b1, KIND_HEADER, 1'b1},
      '{8'hff, 8'd0, TYPE_TRUECOLOUR, DEPTH_32, 16'hffff, 16'hffff, 5, PACK_MIXED, 0,
        1'b1, KIND_HEADER, 1'b0},
      '{8'd0, 8'd0, TYPE_RLE, DEPTH_24, 16'd2, 16'd2, 0, PACK_MIXED, 9,
        1'b0, KIND_HEADER, 1'b0},
      '{8'd0, 8'd0, TYPE_RLE, DEPTH_24, 16'd2, 16'd1, 2, PACK_MIXED, 0,
        1'b1, KIND_HEADER, 1'b0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    put_byte(8'hff, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h5a, 1'b0);
    for (k = 0; k < $size(directed_plan); k++) begin
      full_rate <= ($urandom_range(0, 3) == 0);
      send_tga(directed_plan[k]);
    end

    decoded_bytes = 0;
    while (decoded_bytes < RANDOM_BYTES) begin
      full_rate <= ($urandom_range(0, 3) == 0);
      f = '0;
      f.itype = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
              : (($urandom_range(0, 2) == 0) ? TYPE_TRUECOLOUR : TYPE_RLE);
      f.cmap = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      f.depth = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255))
              : (($urandom_range(0, 1) == 0) ? DEPTH_24 : DEPTH_32);
      f.id_len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 12)) : 8'd0;
      sel = $urandom_range(0, 29);
      if (sel == 0) begin
        f.w = 16'd0;
        f.h = 16'($urandom_range(0, 3));
      end else if (sel == 1) begin
        f.w = 16'($urandom_range(1, 3));
        f.h = 16'd0;
      end else if (sel < 4) begin
        f.w = 16'($urandom_range(200, 65535));
        f.h = 16'($urandom_range(1, 65535));
      end else begin
        f.w = 16'($urandom_range(1, 4));
        f.h = 16'($urandom_range(1, 3));
      end
      area = int'(f.w) * int'(f.h);
      if (sel >= 2 && sel < 4) f.pixels = $urandom_range(1, 12);
      else f.pixels = area;
      sel = $urandom_range(0, 7);
      if (sel == 0 && area > 0 && area < 100) f.pixels = $urandom_range(0, area - 1);
      else if (sel == 1) f.pixels = f.pixels + $urandom_range(1, 6);
      f.packing = ($urandom_range(0, 15) == 0) ? PACK_RUNS : PACK_MIXED;
      f.hdr_cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 17) : 0;
      send_tga(f);
    end
    byte_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Streamed %0d files; %0d random-phase bytes reached the parser.",
             files_sent, decoded_bytes);
    $display("Checked %0d result beats: %0d pixel runs, %0d header errors.",
             results_seen, runs_predicted, header_errors);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_tga_truecolor_rle_decoder_core OK");
    end else begin
      $display("tb_tga_truecolor_rle_decoder_core NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
design/tgarle_pkg.sv
design/tgarle_row_div.sv
design/tga_truecolor_rle_decoder_core.sv
design/tgarle_checker.sv
verif/tb_tga_truecolor_rle_decoder_core.sv
